FILE: rtl/core/fwss_pkg.sv
// shared constants, command codes and cell control type for the fifo with stack snapshot
package fwss_pkg;

    localparam int DEPTH   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_SNAP = 2'd2,
        CMD_DUMP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic               snap;
        logic               rot;
        logic [CNT_W-1:0]   q_count;
        logic [CNT_W-1:0]   s_last;
        logic [VALUE_W-1:0] value;
    } ctl_t;

endpackage

FILE: rtl/core/fwss_cell.sv
// one cell of the row: a queue entry and a stack entry, shifting toward cell zero
module fwss_cell
(
    input  logic                          clk,
    input  fwss_pkg::ctl_t                ctl,
    input  logic [fwss_pkg::CNT_W-1:0]    cell_index,
    input  logic [fwss_pkg::VALUE_W-1:0]  q_from_next,
    input  logic [fwss_pkg::VALUE_W-1:0]  s_from_next,
    input  logic [fwss_pkg::VALUE_W-1:0]  s_from_first,
    output logic [fwss_pkg::VALUE_W-1:0]  q_val,
    output logic [fwss_pkg::VALUE_W-1:0]  s_val
);

    logic [fwss_pkg::VALUE_W-1:0] q_reg;
    logic [fwss_pkg::VALUE_W-1:0] q_next;
    logic [fwss_pkg::VALUE_W-1:0] s_reg;
    logic [fwss_pkg::VALUE_W-1:0] s_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.enq && (cell_index == ctl.q_count))
        begin
            q_next = ctl.value;
        end
        else if (ctl.deq)
        begin
            q_next = q_from_next;
        end
    end

    // rotation wraps at the bottom entry so a dump leaves the stack as it was
    always_comb
    begin
        s_next = s_reg;
        if (ctl.snap)
        begin
            s_next = q_reg;
        end
        else if (ctl.rot)
        begin
            s_next = (cell_index == ctl.s_last) ? s_from_first : s_from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        s_reg <= s_next;
    end

    assign q_val = q_reg;
    assign s_val = s_reg;

endmodule

FILE: rtl/core/fifo_with_stack_snapshot_top.sv
// top level of the fifo with stack snapshot: command decode, counters, cell row and output stage
//
// bounded fifo of signed 32-bit values plus a snapshot stack, built as a row of cells
// slave channel: one request per command, s_tuser carries the command, s_tdata the value
//   enqueue appends s_tdata (dropped when full), dequeue drops the head (no-op when empty),
//   snapshot copies the whole fifo into the stack, all cells together, head on top,
//   dump streams the stack top first on the master channel, m_tlast on the bottom entry
// enqueue, dequeue and snapshot are accepted back to back while no dump is running
// a dump holds s_tready low until its last entry is emitted, longer under master stalls; the stack
//   row rotates one place per emitted entry and is back in order when the dump ends
// the first dump result passes the state register and then the output stage before m_tvalid rises
// a registered output stage parts the channels; when m_tready is low and a result is pending
//   the row holds its position and the pending result stays on m_tdata
// reset (rst_n low, asynchronous) empties fifo and stack; the cell contents themselves
//   are not cleared, entries past the counts are never read
module fifo_with_stack_snapshot_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fwss_pkg::VALUE_W-1:0]  s_tdata,   // value
    input  logic [fwss_pkg::CMD_W-1:0]    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fwss_pkg::VALUE_W-1:0]  m_tdata,   // value_out
    output logic                          m_tlast
);

    fwss_pkg::state_t             state_reg;
    fwss_pkg::state_t             state_next;
    logic [fwss_pkg::CNT_W-1:0]   q_count_reg;
    logic [fwss_pkg::CNT_W-1:0]   q_count_next;
    logic [fwss_pkg::CNT_W-1:0]   s_count_reg;
    logic [fwss_pkg::CNT_W-1:0]   s_count_next;
    logic [fwss_pkg::CNT_W-1:0]   remain_reg;
    logic [fwss_pkg::CNT_W-1:0]   remain_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [fwss_pkg::VALUE_W-1:0] m_tdata_reg;
    logic [fwss_pkg::VALUE_W-1:0] m_tdata_next;
    logic                         m_tlast_reg;
    logic                         m_tlast_next;

    logic                         accept;
    logic                         emit;
    fwss_pkg::cmd_t               cmd;
    fwss_pkg::ctl_t               ctl;

    logic [fwss_pkg::VALUE_W-1:0] q_bus [fwss_pkg::DEPTH];
    logic [fwss_pkg::VALUE_W-1:0] s_bus [fwss_pkg::DEPTH];

    assign cmd      = fwss_pkg::cmd_t'(s_tuser);
    assign s_tready = (state_reg == fwss_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // a dump step moves one entry when the output stage is free or being drained
    assign emit     = (state_reg == fwss_pkg::ST_DUMP) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        ctl         = '0;
        ctl.enq     = accept && (cmd == fwss_pkg::CMD_ENQ)
                      && (q_count_reg != fwss_pkg::CNT_W'(fwss_pkg::DEPTH));
        ctl.deq     = accept && (cmd == fwss_pkg::CMD_DEQ) && (q_count_reg != '0);
        ctl.snap    = accept && (cmd == fwss_pkg::CMD_SNAP);
        ctl.rot     = emit;
        ctl.q_count = q_count_reg;
        ctl.s_last  = s_count_reg - fwss_pkg::CNT_W'(1);
        ctl.value   = s_tdata;
    end

    // the row of cells; the bottom cell feeds itself, and what it shifts in is never read
    for (genvar i = 0; i < fwss_pkg::DEPTH; i++)
    begin : g_cell
        logic [fwss_pkg::VALUE_W-1:0] q_nb;
        logic [fwss_pkg::VALUE_W-1:0] s_nb;

        if (i == fwss_pkg::DEPTH - 1)
        begin : g_end
            assign q_nb = q_bus[i];
            assign s_nb = s_bus[i];
        end
        else
        begin : g_mid
            assign q_nb = q_bus[i+1];
            assign s_nb = s_bus[i+1];
        end

        fwss_cell u_cell
        (
            .clk          (clk),
            .ctl          (ctl),
            .cell_index   (fwss_pkg::CNT_W'(i)),
            .q_from_next  (q_nb),
            .s_from_next  (s_nb),
            .s_from_first (s_bus[0]),
            .q_val        (q_bus[i]),
            .s_val        (s_bus[i])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        q_count_next  = q_count_reg;
        s_count_next  = s_count_reg;
        remain_next   = remain_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            fwss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        fwss_pkg::CMD_ENQ:
                        begin
                            if (ctl.enq)
                            begin
                                q_count_next = q_count_reg + fwss_pkg::CNT_W'(1);
                            end
                        end
                        fwss_pkg::CMD_DEQ:
                        begin
                            if (ctl.deq)
                            begin
                                q_count_next = q_count_reg - fwss_pkg::CNT_W'(1);
                            end
                        end
                        fwss_pkg::CMD_SNAP:
                        begin
                            s_count_next = q_count_reg;
                        end
                        fwss_pkg::CMD_DUMP:
                        begin
                            // empty stack: nothing to send, stay idle
                            if (s_count_reg != '0)
                            begin
                                state_next  = fwss_pkg::ST_DUMP;
                                remain_next = s_count_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fwss_pkg::ST_DUMP:
            begin
                if (emit)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = s_bus[0];
                    m_tlast_next  = (remain_reg == fwss_pkg::CNT_W'(1));
                    remain_next   = remain_reg - fwss_pkg::CNT_W'(1);
                    if (remain_reg == fwss_pkg::CNT_W'(1))
                    begin
                        state_next = fwss_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = fwss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fwss_pkg::ST_IDLE;
            q_count_reg  <= '0;
            s_count_reg  <= '0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            q_count_reg  <= q_count_next;
            s_count_reg  <= s_count_next;
            remain_reg   <= remain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload needs no reset
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // the fifo never holds more than the row has cells
    a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= fwss_pkg::CNT_W'(fwss_pkg::DEPTH))
        else $error("queue count above depth");

    // the stack row only rotates while a dump is running
    a_rot_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rot |-> (state_reg == fwss_pkg::ST_DUMP))
        else $error("stack rotation outside dump");

    // the bottom entry of a dump is flagged last and ends the dump
    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (remain_reg == fwss_pkg::CNT_W'(1)))
        |=> (m_tvalid_reg && m_tlast_reg && (state_reg == fwss_pkg::ST_IDLE)))
        else $error("dump did not end on last entry");

    // the stack count moves only on a snapshot request
    a_scount_snap: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.snap |=> (s_count_reg == $past(s_count_reg)))
        else $error("stack count changed without snapshot");
`endif

endmodule

FILE: tb/tb_fifo_with_stack_snapshot_top.sv
// self-checking testbench for the fifo with stack snapshot top level
module tb_fifo_with_stack_snapshot_top;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request moving on either side
    localparam int DRAIN_CYCLES   = 20;    // quiet time after the last result
    localparam int RANDOM_ITEMS   = 150;

    typedef struct {
        logic [fwss_pkg::VALUE_W-1:0] value;
        logic                         last;
    } dump_entry_t;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [fwss_pkg::VALUE_W-1:0] s_tdata  = '0;
    logic [fwss_pkg::CMD_W-1:0]   s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [fwss_pkg::VALUE_W-1:0] m_tdata;
    logic                         m_tlast;

    // shadow state of the block: circular fifo and the snapshot stack, top at index 0
    logic [fwss_pkg::VALUE_W-1:0] fifo_mem [fwss_pkg::DEPTH];
    int                           fifo_head;
    int                           fifo_count;
    logic [fwss_pkg::VALUE_W-1:0] stack_mem [fwss_pkg::DEPTH];
    int                           stack_depth;

    // dump results still owed by the block, oldest first
    dump_entry_t        dump_expect [$];

    bit                 no_gaps;          // when set, neither side idles
    int                 fail_count;
    int                 requests_sent;
    int                 dumps_sent;
    int                 entries_checked;
    int                 full_drops;
    int                 empty_dequeues;

    fifo_with_stack_snapshot_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // operand value with the corners showing up often
    function automatic logic [fwss_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // update the shadow state for one accepted request; returns 1 when it had any effect
    function automatic bit apply_command(fwss_pkg::cmd_t cmd,
                                         logic [fwss_pkg::VALUE_W-1:0] val);
        dump_entry_t e;
        case (cmd)
            fwss_pkg::CMD_ENQ:
            begin
                if (fifo_count >= fwss_pkg::DEPTH)
                begin
                    full_drops++;
                    return 1'b0;
                end
                fifo_mem[(fifo_head + fifo_count) % fwss_pkg::DEPTH] = val;
                fifo_count++;
                return 1'b1;
            end
            fwss_pkg::CMD_DEQ:
            begin
                if (fifo_count == 0)
                begin
                    empty_dequeues++;
                    return 1'b0;
                end
                fifo_head = (fifo_head + 1) % fwss_pkg::DEPTH;
                fifo_count--;
                return 1'b1;
            end
            fwss_pkg::CMD_SNAP:
            begin
                // head of the fifo lands on top of the stack, fifo untouched
                for (int i = 0; i < fifo_count; i++)
                    stack_mem[i] = fifo_mem[(fifo_head + i) % fwss_pkg::DEPTH];
                stack_depth = fifo_count;
                return 1'b1;
            end
            default:
            begin
                dumps_sent++;
                for (int i = 0; i < stack_depth; i++)
                begin
                    e.value = stack_mem[i];
                    e.last  = (i == stack_depth - 1);
                    dump_expect.push_back(e);
                end
                return stack_depth != 0;
            end
        endcase
    endfunction

    // one request on the slave side; returns once it is accepted
    task automatic send_request(input fwss_pkg::cmd_t cmd,
                                input logic [fwss_pkg::VALUE_W-1:0] val,
                                output bit effective);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            // valid drops only when a gap follows, junk on the data lines meanwhile
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= fwss_pkg::CMD_W'($urandom_range(0, 3));
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        effective = apply_command(cmd, val);
    endtask

    task automatic send(input fwss_pkg::cmd_t cmd,
                        input logic [fwss_pkg::VALUE_W-1:0] val = '0);
        bit eff;
        send_request(cmd, val, eff);
    endtask

    // commands on an empty fifo and an empty stack produce nothing
    task automatic test_empty_corners();
        send(fwss_pkg::CMD_DUMP);
        send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_SNAP);
        send(fwss_pkg::CMD_DUMP);
    endtask

    // value extremes through the fifo, snapshot order, and the stack surviving dequeues
    task automatic test_value_extremes();
        send(fwss_pkg::CMD_ENQ, 32'h8000_0000);
        send(fwss_pkg::CMD_ENQ, 32'h7fff_ffff);
        send(fwss_pkg::CMD_ENQ, 32'h0000_0000);
        send(fwss_pkg::CMD_ENQ, 32'hffff_ffff);
        send(fwss_pkg::CMD_ENQ, 32'haaaa_5555);
        send(fwss_pkg::CMD_SNAP);
        send(fwss_pkg::CMD_DUMP);
        send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_DUMP);   // stack unchanged by the dequeue
        send(fwss_pkg::CMD_SNAP);
        send(fwss_pkg::CMD_DUMP);
        send(fwss_pkg::CMD_DUMP);   // dump is not destructive
        // single entry stack: first result is also the last
        send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_SNAP);
        send(fwss_pkg::CMD_DUMP);
        send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_SNAP);   // empty fifo clears the stack
        send(fwss_pkg::CMD_DUMP);
    endtask

    // fill past full, longest dump, then drain past empty
    task automatic test_fill_and_overflow();
        for (int i = 0; i < fwss_pkg::DEPTH + 3; i++)
            send(fwss_pkg::CMD_ENQ, pick_value());
        send(fwss_pkg::CMD_SNAP);
        send(fwss_pkg::CMD_DUMP);
        for (int i = 0; i < fwss_pkg::DEPTH + 2; i++)
            send(fwss_pkg::CMD_DEQ);
        send(fwss_pkg::CMD_DUMP);
        send(fwss_pkg::CMD_SNAP);
        send(fwss_pkg::CMD_DUMP);
    endtask

    // weighted command mix, keeps the fifo level wandering so the head wraps many times
    task automatic test_random_traffic(input int n_items);
        int             done;
        int             r;
        fwss_pkg::cmd_t cmd;
        bit             eff;
        done = 0;
        while (done < n_items)
        begin
            // every so often switch to a stretch with no idling on either side
            if ($urandom_range(0, 49) == 0)
                no_gaps = ~no_gaps;
            r = $urandom_range(0, 99);
            if (fifo_count == 0 && r < 70)
                cmd = fwss_pkg::CMD_ENQ;
            else if (r < 48)
                cmd = fwss_pkg::CMD_ENQ;
            else if (r < 78)
                cmd = fwss_pkg::CMD_DEQ;
            else if (r < 89)
                cmd = fwss_pkg::CMD_SNAP;
            else
                cmd = fwss_pkg::CMD_DUMP;
            send_request(cmd, pick_value(), eff);
            if (eff)
                done++;
        end
        no_gaps = 1'b0;
    endtask

    // result checker and master-side stall generator
    initial
    begin
        int          stall;
        dump_entry_t e;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (dump_expect.size() == 0)
                begin
                    $error("unexpected result: m_tdata %0d m_tlast %0b",
                           $signed(m_tdata), m_tlast);
                    fail_count++;
                end
                else
                begin
                    e = dump_expect.pop_front();
                    entries_checked++;
                    if (m_tdata !== e.value)
                    begin
                        $error("value_out mismatch: expected %0d actual %0d",
                               $signed(e.value), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last mismatch: expected %0b actual %0b", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (!rst_n)
                m_tready <= 1'b0;
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // watchdog: too long with nothing moving on either channel ends the run
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle, dump_expect.size());
                $display("fifo_with_stack_snapshot_top regression: fail");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        fifo_head   = 0;
        fifo_count  = 0;
        stack_depth = 0;
        no_gaps     = 1'b0;
        fail_count  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_corners();
        test_value_extremes();
        test_fill_and_overflow();
        test_random_traffic(RANDOM_ITEMS);
        test_fill_and_overflow();
        s_tvalid <= 1'b0;

        while (dump_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests with %0d dumps and %0d stack entries checked",
                 requests_sent, dumps_sent, entries_checked);
        $display("corners hit: %0d enqueues dropped on full, %0d dequeues on empty",
                 full_drops, empty_dequeues);
        if (fail_count == 0)
            $display("fifo_with_stack_snapshot_top regression: pass");
        else
            $display("fifo_with_stack_snapshot_top regression: fail");
        $finish;
    end

endmodule

FILE: fifo_with_stack_snapshot_top.f
rtl/core/fwss_pkg.sv
rtl/core/fwss_cell.sv
rtl/core/fifo_with_stack_snapshot_top.sv
tb/tb_fifo_with_stack_snapshot_top.sv
